FILE: design/mersenne_twister_word_generator_unit_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros used by the checker file of the word generator.
// -----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_WORD_GENERATOR_UNIT_MACROS_SVH
`define MERSENNE_TWISTER_WORD_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtwg checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtwg checker: next-cycle property failed");

`endif

FILE: design/mtwg_pkg.sv
// -----------------------------------------------------------------------------
// mtwg_pkg
// Constants, action codes and the tempering function of the word generator.
// -----------------------------------------------------------------------------
package mtwg_pkg;

  localparam int unsigned IDX_W = 10;

  localparam logic [IDX_W-1:0] WORD_COUNT   = 10'd624;
  localparam logic [IDX_W-1:0] LAST_IDX     = 10'd623;
  localparam logic [IDX_W-1:0] NEVER_SEEDED = 10'd625;
  localparam logic [IDX_W-1:0] FAR_OFFSET   = 10'd397;
  localparam logic [IDX_W-1:0] FAR_BACK     = 10'd227;

  localparam logic [31:0] DEFAULT_SEED = 32'd4357;
  localparam logic [31:0] TWIST_A      = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] LCG_MUL      = 32'd69069;

  localparam logic [1:0] ACT_DRAW = 2'd0;
  localparam logic [1:0] ACT_SEED = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: design/mtwg_if.sv
// -----------------------------------------------------------------------------
// mtwg channel interfaces
// Valid/ready channels for request words and result words.
// -----------------------------------------------------------------------------
interface mtwg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] seed_value;
  logic [9:0]  word_index;
  logic [31:0] word_value;

  modport source (output valid, output action, output seed_value,
                  output word_index, output word_value, input ready);
  modport sink   (input valid, input action, input seed_value,
                  input word_index, input word_value, output ready);
endinterface

interface mtwg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

FILE: design/mersenne_twister_word_generator_unit.sv
// Draw from a live store: ST_DRAW_RD reads, ST_DRAW_OUT registers the tempered word, held
// while an earlier word is unread; no request is taken till then. On an exhausted store a
// draw first twists it: a read ahead, then per word a neighbor read, a far read, a write,
// sharing one RAM read port. Seeding runs ST_SEED_A, ST_SEED_B per word; a never-seeded
// draw seeds first. Reset leaves the pointer at never-seeded; the RAM is not cleared.
// -----------------------------------------------------------------------------
// mersenne_twister_word_generator_unit
// MT19937 generator around a 624-word state RAM with seed, load and draw actions.
// -----------------------------------------------------------------------------
module mersenne_twister_word_generator_unit (
  input  logic             clk,
  input  logic             rst_n,
  mtwg_in_if.sink          in_ch,
  mtwg_out_if.source       out_ch
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEED_A   = 4'd1;
  localparam logic [3:0] ST_SEED_B   = 4'd2;
  localparam logic [3:0] ST_TW_R0    = 4'd3;
  localparam logic [3:0] ST_TW_RN    = 4'd4;
  localparam logic [3:0] ST_TW_RF    = 4'd5;
  localparam logic [3:0] ST_TW_WR    = 4'd6;
  localparam logic [3:0] ST_DRAW_RD  = 4'd7;
  localparam logic [3:0] ST_DRAW_OUT = 4'd8;

  logic [31:0] state_mem_r [0:623];
  logic [31:0] rd_data_r;

  logic [3:0]  state_r, state_nxt;
  logic [9:0]  ptr_r, ptr_nxt;
  logic [9:0]  cnt_r, cnt_nxt;
  logic        draw_pend_r, draw_pend_nxt;
  logic [31:0] lcg_r, lcg_nxt;
  logic [31:0] lcg1_r, lcg1_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] nword_r, nword_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;

  logic        we;
  logic [9:0]  wa;
  logic [31:0] wd;
  logic        re;
  logic [9:0]  ra;

  logic        accept;
  logic [31:0] mul_in;
  logic [31:0] mul_out;
  logic [31:0] twist_y;
  logic [31:0] twist_v;
  logic [9:0]  nxt_idx;
  logic [9:0]  far_idx;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  // One shared constant multiplier serves both halves of the seed recurrence.
  assign mul_in  = (state_r == ST_SEED_A) ? lcg_r : lcg1_r;
  assign mul_out = 32'(mul_in * mtwg_pkg::LCG_MUL) + 32'd1;

  assign nxt_idx = (cnt_r == mtwg_pkg::LAST_IDX) ? '0 : cnt_r + 10'd1;
  assign far_idx = (cnt_r < mtwg_pkg::FAR_BACK) ? cnt_r + mtwg_pkg::FAR_OFFSET
                                                : cnt_r - mtwg_pkg::FAR_BACK;

  assign twist_y = {cur_r[31], nword_r[30:0]};
  assign twist_v = rd_data_r ^ (twist_y >> 1) ^ (twist_y[0] ? mtwg_pkg::TWIST_A : '0);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    draw_pend_nxt = draw_pend_r;
    lcg_nxt       = lcg_r;
    lcg1_nxt      = lcg1_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    nword_nxt     = nword_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    we            = 1'b0;
    wa            = cnt_r;
    wd            = twist_v;
    re            = 1'b0;
    ra            = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.action)
            mtwg_pkg::ACT_DRAW: begin
              if (ptr_r == mtwg_pkg::NEVER_SEEDED) begin
                lcg_nxt       = mtwg_pkg::DEFAULT_SEED;
                cnt_nxt       = '0;
                draw_pend_nxt = 1'b1;
                state_nxt     = ST_SEED_A;
              end else if (ptr_r == mtwg_pkg::WORD_COUNT) begin
                cnt_nxt   = '0;
                state_nxt = ST_TW_R0;
              end else begin
                state_nxt = ST_DRAW_RD;
              end
            end
            mtwg_pkg::ACT_SEED: begin
              lcg_nxt       = in_ch.seed_value;
              cnt_nxt       = '0;
              draw_pend_nxt = 1'b0;
              state_nxt     = ST_SEED_A;
            end
            mtwg_pkg::ACT_LOAD: begin
              if (in_ch.word_index < mtwg_pkg::WORD_COUNT) begin
                we      = 1'b1;
                wa      = in_ch.word_index;
                wd      = in_ch.word_value;
                ptr_nxt = mtwg_pkg::WORD_COUNT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEED_A: begin
        hi_nxt    = lcg_r[31:16];
        lcg1_nxt  = mul_out;
        state_nxt = ST_SEED_B;
      end
      ST_SEED_B: begin
        we      = 1'b1;
        wd      = {hi_r, lcg1_r[31:16]};
        lcg_nxt = mul_out;
        cnt_nxt = cnt_r + 10'd1;
        if (cnt_r == mtwg_pkg::LAST_IDX) begin
          ptr_nxt = mtwg_pkg::WORD_COUNT;
          if (draw_pend_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_TW_R0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SEED_A;
        end
      end
      ST_TW_R0: begin
        re        = 1'b1;
        state_nxt = ST_TW_RN;
      end
      ST_TW_RN: begin
        // The first word comes from the read issued just before the loop;
        // later words are carried over from the previous neighbor read.
        if (cnt_r == '0) begin
          cur_nxt = rd_data_r;
        end
        re        = 1'b1;
        ra        = nxt_idx;
        state_nxt = ST_TW_RF;
      end
      ST_TW_RF: begin
        nword_nxt = rd_data_r;
        re        = 1'b1;
        ra        = far_idx;
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        we      = 1'b1;
        cur_nxt = nword_r;
        cnt_nxt = cnt_r + 10'd1;
        if (cnt_r == mtwg_pkg::LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = ST_DRAW_RD;
        end else begin
          state_nxt = ST_TW_RN;
        end
      end
      ST_DRAW_RD: begin
        re        = 1'b1;
        ra        = ptr_r;
        state_nxt = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtwg_pkg::temper(rd_data_r);
          ptr_nxt       = ptr_r + 10'd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      state_mem_r[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= state_mem_r[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= mtwg_pkg::NEVER_SEEDED;
      cnt_r       <= '0;
      draw_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      draw_pend_r <= draw_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcg_r      <= lcg_nxt;
    lcg1_r     <= lcg1_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    nword_r    <= nword_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

FILE: design/mtwg_checker.sv
// -----------------------------------------------------------------------------
// mtwg_checker
// Port-level properties of the word generator, attached by bind.
// -----------------------------------------------------------------------------
`include "mersenne_twister_word_generator_unit_macros.svh"

module mtwg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready
);

  logic in_acc;
  logic quick_act;

  assign in_acc    = in_valid && in_ready;
  assign quick_act = (in_action == mtwg_pkg::ACT_LOAD) || (in_action == mtwg_pkg::ACT_NOP);

  // A pending result word is held until it is taken.
  `MTWG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Draws and seeds occupy the generator for at least the following cycle.
  `MTWG_ASSERT_NEXT(a_busy_after_work, clk, rst_n, in_acc && !quick_act, !in_ready)

  // Loads and unused actions finish in the cycle they are taken.
  `MTWG_ASSERT_NEXT(a_quick_ready, clk, rst_n, in_acc && quick_act, in_ready)

  // A new result word only appears after a busy cycle of the generator.
  `MTWG_ASSERT_NOW(a_word_after_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind mersenne_twister_word_generator_unit mtwg_checker u_mtwg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
